// ===== rtl/pp_pkg.sv =====
// Shared types, constants and helpers for the perspective point projection unit.
`timescale 1ns / 1ps
`default_nettype none
package pp_pkg;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_PROJECT = 1'b1;

    localparam logic [1:0] CFG_WINDOW_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_WINDOW_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_MIN_CLIP_W    = 2'd2;

    localparam logic [13:0] WINDOW_WIDTH_RST  = 14'd1024;
    localparam logic [13:0] WINDOW_HEIGHT_RST = 14'd768;
    localparam logic [30:0] MIN_CLIP_W_RST    = 31'd6554;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        logic               opcode;
        logic [3:0]         coef_index;
        logic signed [31:0] coef_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } in_word_t;

    typedef struct packed {
        logic               visible;
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
    } out_word_t;

    // clip coordinates handed from front to back
    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cw;
    } clip_t;

    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        logic signed [31:0] r;
        if (v > 72'sd2147483647) begin
            r = 32'sh7fff_ffff;
        end else if (v < -72'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/pp_front.sv =====
// Front end: accepts words, keeps the matrix, computes clip x, y and w.
`timescale 1ns / 1ps
`default_nettype none
module pp_front import pp_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_word_t s_data,
    output logic          push_valid,
    input  wire logic     push_full,
    output clip_t         push_data
);

    logic signed [31:0] coef_reg [16];
    logic               s1_valid_reg;
    logic               s2_valid_reg;
    logic               en;
    logic               acc;
    logic signed [31:0] clip_val [3];

    assign en      = !s2_valid_reg || !push_full;
    assign s_ready = en;
    assign acc     = s_valid && en;

    always_ff @(posedge aclk) begin
        if (acc && s_data.opcode == OP_LOAD) begin
            coef_reg[s_data.coef_index] <= s_data.coef_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= acc && s_data.opcode == OP_PROJECT;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // lanes 0, 1, 2 compute matrix rows 0, 1, 3
    for (genvar ln = 0; ln < 3; ln++) begin : g_lane
        localparam int ROW = (ln == 2) ? 3 : ln;
        logic signed [63:0] p0_reg, p1_reg, p2_reg;
        logic signed [31:0] t1_reg, t2_reg;
        logic signed [65:0] psum_reg;
        logic signed [71:0] wide;

        always_ff @(posedge aclk) begin
            if (en) begin
                p0_reg   <= s_data.pos_x * coef_reg[ROW];
                p1_reg   <= s_data.pos_y * coef_reg[4 + ROW];
                p2_reg   <= s_data.pos_z * coef_reg[8 + ROW];
                t1_reg   <= coef_reg[12 + ROW];
                psum_reg <= 66'(p0_reg) + 66'(p1_reg) + 66'(p2_reg);
                t2_reg   <= t1_reg;
            end
        end

        // floor of the exact sum equals the sum of floors plus floor of the fractions
        assign wide          = (72'(psum_reg) >>> FRAC_BITS) + 72'(t2_reg);
        assign clip_val[ln]  = sat32(wide);
    end

    assign push_valid   = s2_valid_reg && en;
    assign push_data.cx = clip_val[0];
    assign push_data.cy = clip_val[1];
    assign push_data.cw = clip_val[2];

endmodule
`default_nettype wire

// ===== rtl/pp_queue.sv =====
// Short queue of clip words between front and back.
`timescale 1ns / 1ps
`default_nettype none
module pp_queue import pp_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire clip_t push_data,
    output logic       full,
    input  wire logic  pop,
    output logic       empty,
    output clip_t      head
);

    clip_t                  mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]    wr_ptr_reg;
    logic [QUEUE_AW-1:0]    rd_ptr_reg;
    logic [QUEUE_AW:0]      count_reg;
    logic                   do_pop;

    assign full   = count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH);
    assign empty  = count_reg == '0;
    assign head   = mem_reg[rd_ptr_reg];
    assign do_pop = pop && !empty;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (QUEUE_AW + 1)'(push) - (QUEUE_AW + 1)'(do_pop);
        end
    end

endmodule
`default_nettype wire

// ===== rtl/pp_back.sv =====
// Back end: visibility test, pipelined division and viewport mapping.
`timescale 1ns / 1ps
`default_nettype none
module pp_back import pp_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [13:0] window_width,
    input  wire logic [13:0] window_height,
    input  wire logic [30:0] min_clip_w,
    input  wire logic        q_empty,
    input  wire clip_t       q_head,
    output logic             q_pop,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_word_t        m_data
);

    localparam int NW = 32 + FRAC_BITS;

    logic               en;
    logic               m_valid_reg;
    out_word_t          m_data_reg;

    // divider stage k holds the word after k quotient bits
    logic               dv_valid_reg [NW + 1];
    logic               dv_vis_reg   [NW + 1];
    logic               dv_negx_reg  [NW + 1];
    logic               dv_negy_reg  [NW + 1];
    logic [30:0]        dv_d_reg     [NW + 1];
    logic [30:0]        dv_rx_reg    [NW + 1];
    logic [30:0]        dv_ry_reg    [NW + 1];
    logic [NW-1:0]      dv_qx_reg    [NW + 1];
    logic [NW-1:0]      dv_qy_reg    [NW + 1];

    logic               sat_valid_reg, mul_valid_reg;
    logic               sat_vis_reg, mul_vis_reg;
    logic signed [31:0] nx_reg, ny_reg, mnx_reg, mny_reg;
    logic signed [45:0] mx_reg, my_reg;

    logic               vis;
    logic [31:0]        ax, ay;
    logic [12:0]        hw, hh;
    logic signed [31:0] nx_next, ny_next;
    logic signed [71:0] sx_wide, sy_wide;

    assign en      = !m_valid_reg || m_ready;
    assign q_pop   = en && !q_empty;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign hw      = window_width[13:1];
    assign hh      = window_height[13:1];

    assign vis = !q_head.cw[31] && q_head.cw != '0 && q_head.cw[30:0] >= min_clip_w;
    assign ax  = q_head.cx[31] ? 32'(-q_head.cx) : 32'(q_head.cx);
    assign ay  = q_head.cy[31] ? 32'(-q_head.cy) : 32'(q_head.cy);

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_vis_reg[0]  <= vis;
            dv_negx_reg[0] <= q_head.cx[31];
            dv_negy_reg[0] <= q_head.cy[31];
            dv_d_reg[0]    <= q_head.cw[30:0];
            dv_rx_reg[0]   <= '0;
            dv_ry_reg[0]   <= '0;
            dv_qx_reg[0]   <= {ax, FRAC_BITS'(0)};
            dv_qy_reg[0]   <= {ay, FRAC_BITS'(0)};
        end
    end

    for (genvar k = 0; k < NW; k++) begin : g_div
        logic [31:0] tx, ty;
        logic        bx, by;

        assign tx = {dv_rx_reg[k], dv_qx_reg[k][NW-1]};
        assign ty = {dv_ry_reg[k], dv_qy_reg[k][NW-1]};
        assign bx = tx >= {1'b0, dv_d_reg[k]};
        assign by = ty >= {1'b0, dv_d_reg[k]};

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_vis_reg[k+1]  <= dv_vis_reg[k];
                dv_negx_reg[k+1] <= dv_negx_reg[k];
                dv_negy_reg[k+1] <= dv_negy_reg[k];
                dv_d_reg[k+1]    <= dv_d_reg[k];
                dv_rx_reg[k+1]   <= bx ? 31'(tx - {1'b0, dv_d_reg[k]}) : tx[30:0];
                dv_ry_reg[k+1]   <= by ? 31'(ty - {1'b0, dv_d_reg[k]}) : ty[30:0];
                dv_qx_reg[k+1]   <= {dv_qx_reg[k][NW-2:0], bx};
                dv_qy_reg[k+1]   <= {dv_qy_reg[k][NW-2:0], by};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                dv_valid_reg[k+1] <= dv_valid_reg[k];
            end
        end
    end

    function automatic logic signed [31:0] sat_quot(input logic [NW-1:0] q, input logic neg);
        logic [FRAC_BITS:0] hi;
        logic signed [31:0] r;
        hi = q[NW-1:31];
        if (!neg) begin
            r = (hi != '0) ? 32'sh7fff_ffff : $signed(q[31:0]);
        end else if (hi > (FRAC_BITS + 1)'(1) || (hi == (FRAC_BITS + 1)'(1) && q[30:0] != '0)) begin
            r = 32'sh8000_0000;
        end else begin
            r = $signed(-q[31:0]);
        end
        return r;
    endfunction

    assign nx_next = sat_quot(dv_qx_reg[NW], dv_negx_reg[NW]);
    assign ny_next = sat_quot(dv_qy_reg[NW], dv_negy_reg[NW]);

    always_ff @(posedge aclk) begin
        if (en) begin
            sat_vis_reg <= dv_vis_reg[NW];
            nx_reg      <= nx_next;
            ny_reg      <= ny_next;
            mul_vis_reg <= sat_vis_reg;
            mx_reg      <= $signed({1'b0, hw}) * nx_reg;
            my_reg      <= $signed({1'b0, hh}) * ny_reg;
            mnx_reg     <= nx_reg;
            mny_reg     <= ny_reg;
        end
    end

    assign sx_wide = 72'(mx_reg) + 72'(mnx_reg) + (72'(hw) << FRAC_BITS);
    assign sy_wide = -72'(my_reg) + 72'(mny_reg) + (72'(hh) << FRAC_BITS);

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg.visible  <= mul_vis_reg;
            m_data_reg.screen_x <= mul_vis_reg ? sat32($signed(sx_wide)) : '0;
            m_data_reg.screen_y <= mul_vis_reg ? sat32($signed(sy_wide)) : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_valid_reg[0] <= 1'b0;
            sat_valid_reg   <= 1'b0;
            mul_valid_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else if (en) begin
            dv_valid_reg[0] <= q_pop;
            sat_valid_reg   <= dv_valid_reg[NW];
            mul_valid_reg   <= sat_valid_reg;
            m_valid_reg     <= mul_valid_reg;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/perspective_point_projection_unit.sv =====
// Top level of the perspective point projection unit.
//
//  channel   ports                               direction  word
//  s_        s_valid / s_ready / s_data          in         in_word_t
//  m_        m_valid / m_ready / m_data          out        out_word_t
//  cfg_      cfg_valid / cfg_ready / idx, data   in         register write
//
// One word per cycle in both directions when m_ready stays high.
// A project word passes 2 front stages, the queue, 1 + (32 + FRAC_BITS) divider
// stages (one quotient bit per stage), saturate, multiply and output register.
// Load words update the matrix at acceptance and produce no result.
// A stall on m_ready holds the back pipeline; the 4-word queue lets the front run on.
// Reset (aresetn low, synchronous) clears control state and the registers to defaults.
`timescale 1ns / 1ps
`default_nettype none
module perspective_point_projection_unit import pp_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_word_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_word_t        m_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    logic [13:0] window_width_reg;
    logic [13:0] window_height_reg;
    logic [30:0] min_clip_w_reg;
    logic        push_valid, q_full, q_pop, q_empty;
    clip_t       push_data, q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_width_reg  <= WINDOW_WIDTH_RST;
            window_height_reg <= WINDOW_HEIGHT_RST;
            min_clip_w_reg    <= MIN_CLIP_W_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_WINDOW_WIDTH:  window_width_reg  <= cfg_data[13:0];
                CFG_WINDOW_HEIGHT: window_height_reg <= cfg_data[13:0];
                CFG_MIN_CLIP_W:    min_clip_w_reg    <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    pp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_full  (q_full),
        .push_data  (push_data)
    );

    pp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push_valid),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    pp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .window_width  (window_width_reg),
        .window_height (window_height_reg),
        .min_clip_w    (min_clip_w_reg),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data)
    );

endmodule
`default_nettype wire

// ===== dv/pp_checker.sv =====
// Scoreboard for the projection unit: watches load, config and result words.
`timescale 1ns / 1ps
module pp_checker import pp_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire in_word_t    s_data,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire out_word_t   m_data,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output int               fail_count,
    output int               pending
);
    localparam int FB = 16;

    logic signed [31:0] mtx [16];
    logic [13:0] win_w, win_h;
    logic [30:0] min_w;
    out_word_t   proj_q[$];

    function automatic logic signed [31:0] clamp32(input logic signed [95:0] v);
        if (v > 96'sd2147483647) return 32'sh7fff_ffff;
        if (v < -96'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // exact sum of full products then floor; same as per-term split form
    function automatic logic signed [31:0] clip_dot(input int row,
            input logic signed [31:0] px, py, pz);
        logic signed [95:0] acc;
        acc = 96'(px) * 96'(mtx[row]) + 96'(py) * 96'(mtx[4 + row])
            + 96'(pz) * 96'(mtx[8 + row]);
        acc = (acc >>> FB) + 96'(mtx[12 + row]);
        return clamp32(acc);
    endfunction

    function automatic out_word_t project_point(input in_word_t w);
        out_word_t r;
        logic signed [31:0] cx, cy, cw, nx, ny;
        logic signed [95:0] hw, hh;
        cx = clip_dot(0, w.pos_x, w.pos_y, w.pos_z);
        cy = clip_dot(1, w.pos_x, w.pos_y, w.pos_z);
        cw = clip_dot(3, w.pos_x, w.pos_y, w.pos_z);
        r = '0;
        if (cw <= 0 || 96'(cw) < 96'(signed'({1'b0, min_w}))) return r;
        nx = clamp32((96'(cx) <<< FB) / 96'(cw));
        ny = clamp32((96'(cy) <<< FB) / 96'(cw));
        hw = 96'(win_w >> 1);
        hh = 96'(win_h >> 1);
        r.visible  = 1'b1;
        r.screen_x = clamp32(hw * 96'(nx) + 96'(nx) + (hw <<< FB));
        r.screen_y = clamp32(-(hh * 96'(ny)) + 96'(ny) + (hh <<< FB));
        return r;
    endfunction

    assign pending = proj_q.size();

    always @(posedge aclk) begin
        out_word_t e;
        if (!aresetn) begin
            win_w <= WINDOW_WIDTH_RST;
            win_h <= WINDOW_HEIGHT_RST;
            min_w <= MIN_CLIP_W_RST;
            fail_count <= 0;
            proj_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_WINDOW_WIDTH:  win_w <= cfg_data[13:0];
                    CFG_WINDOW_HEIGHT: win_h <= cfg_data[13:0];
                    CFG_MIN_CLIP_W:    min_w <= cfg_data[30:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (proj_q.size() == 0) begin
                    $display("%0t: unexpected word exp none act %h", $time, m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    e = proj_q.pop_front();
                    if (e !== m_data) begin
                        $display("%0t: mismatch exp v=%0b x=%h y=%h act v=%0b x=%h y=%h",
                            $time, e.visible, e.screen_x, e.screen_y,
                            m_data.visible, m_data.screen_x, m_data.screen_y);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_data.opcode == OP_LOAD) mtx[s_data.coef_index] = s_data.coef_value;
                else proj_q.push_back(project_point(s_data));
            end
        end
    end
endmodule

// ===== dv/tb.sv =====
// Stimulus and verdict for the perspective point projection unit.
`timescale 1ns / 1ps
module tb import pp_pkg::*;;
    logic aclk, aresetn;
    logic s_valid, s_ready, m_valid, m_ready, cfg_valid, cfg_ready;
    in_word_t s_data;
    out_word_t m_data;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;
    int fail_count, pending;
    int snd_idle, rcv_idle, stall_cnt;
    logic done;

    perspective_point_projection_unit u_dut (.*);
    pp_checker u_chk (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        s_valid = 0; m_ready = 0; cfg_valid = 0; s_data = '0;
        cfg_index = CFG_WINDOW_WIDTH; cfg_data = '0; aresetn = 0;
        snd_idle = 0; rcv_idle = 0; done = 0;
    end

    always @(posedge aclk) m_ready <= ($urandom_range(99) >= rcv_idle);

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_valid || done)
            stall_cnt <= 0;
        else stall_cnt <= stall_cnt + 1;
        if (stall_cnt > 20000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] rnd_q();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom;
            default: return 32'($signed($urandom_range(40'h60000)) - 32'sh30000);
        endcase
    endfunction

    // valid stays up between back-to-back words; it drops only on an idle gap or in drain
    task automatic send(input in_word_t w);
        if ($urandom_range(99) < snd_idle) begin
            s_valid <= 0;
            @(posedge aclk);
            while ($urandom_range(99) < snd_idle) @(posedge aclk);
        end
        s_valid <= 1; s_data <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic load(input int idx, input logic [31:0] v);
        in_word_t w;
        w = '0; w.opcode = OP_LOAD; w.coef_index = 4'(idx); w.coef_value = v;
        w.pos_x = $urandom; w.pos_y = $urandom; w.pos_z = $urandom;
        send(w);
    endtask

    task automatic project(input logic [31:0] x, y, z);
        in_word_t w;
        w.opcode = OP_PROJECT; w.coef_index = 4'($urandom); w.coef_value = $urandom;
        w.pos_x = x; w.pos_y = y; w.pos_z = z;
        send(w);
    endtask

    task automatic drain();
        s_valid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    // plausible perspective matrix with random jitter, or fully random
    task automatic load_matrix(input bit wild);
        for (int i = 0; i < 16; i++) begin
            if (wild) load(i, rnd_q());
            else if (i == 0 || i == 5) load(i, 32'($urandom_range(32'h30000, 32'h4000)));
            else if (i == 11) load(i, 32'h0001_0000);
            else if (i == 15) load(i, 32'($urandom_range(32'h20000)));
            else load(i, 32'($signed($urandom_range(32'h8000)) - 32'sh4000));
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed: identity-ish, then extremes
        for (int i = 0; i < 16; i++) load(i, (i % 5 == 0) ? 32'h0001_0000 : 32'h0);
        project(32'h0000_8000, 32'hffff_8000, 32'h0);
        project(32'h0, 32'h0, 32'h0);
        load(15, 32'h0);
        project(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);      // w zero
        load(15, 32'h7fff_ffff);
        project(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        load(11, 32'h8000_0000);
        project(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        load(0, 32'h7fff_ffff); load(12, 32'h7fff_ffff); load(15, 32'h0000_0001);
        load(11, 32'h0);
        project(32'h7fff_ffff, 32'h7fff_ffff, 32'h0);              // w below min_clip_w
        project(32'hffff_0000, 32'h0, 32'h0);
        drain();
        write_reg(CFG_WINDOW_WIDTH, 32'h3fff);
        write_reg(CFG_WINDOW_HEIGHT, 32'h1);
        write_reg(CFG_MIN_CLIP_W, 32'h0);
        project(32'h7fff_ffff, 32'h1234_5678, 32'h0);
        project(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        drain();
        for (int ph = 0; ph < 6; ph++) begin
            snd_idle = (ph < 2) ? 29 : (ph < 4) ? 86 : 0;
            rcv_idle = (ph < 2) ? 86 : (ph < 4) ? 29 : 0;
            case (ph)
                0: begin write_reg(CFG_WINDOW_WIDTH, 32'd1); write_reg(CFG_WINDOW_HEIGHT, 32'd0);
                          write_reg(CFG_MIN_CLIP_W, 32'h7fff_ffff); end
                1: begin write_reg(CFG_WINDOW_WIDTH, 32'd8192); write_reg(CFG_WINDOW_HEIGHT, 32'd8192);
                          write_reg(CFG_MIN_CLIP_W, 32'd6554); end
                default: begin write_reg(CFG_WINDOW_WIDTH, $urandom_range(8192, 1));
                          write_reg(CFG_WINDOW_HEIGHT, $urandom_range(8192, 1));
                          write_reg(CFG_MIN_CLIP_W, $urandom_range(32'h20000)); end
            endcase
            load_matrix(ph == 5);
            for (int n = 0; n < 70; n++) begin
                if ($urandom_range(9) == 0) load($urandom_range(15), rnd_q());
                else project(rnd_q(), rnd_q(), rnd_q());
            end
            drain();
        end
        done <= 1;
        if (fail_count == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/pp_pkg.sv
rtl/pp_front.sv
rtl/pp_queue.sv
rtl/pp_back.sv
rtl/perspective_point_projection_unit.sv
dv/pp_checker.sv
dv/tb.sv
